[hdl/upd_pkg.sv]
// Shared types, character codes and hex digit decoding for the URL percent decoder.
// No dependencies; used by the channel interfaces and the decoder core.
package upd_pkg;

   localparam int UNIT_W = 16;

   typedef logic [UNIT_W-1:0] char_type;

   localparam char_type CH_PERCENT   = 16'h0025;
   localparam char_type CH_QUESTION  = 16'h003F;
   localparam char_type CH_SLASH     = 16'h002F;
   localparam char_type CH_BACKSLASH = 16'h005C;
   localparam char_type CH_ZERO      = 16'h0030;
   localparam char_type CH_NINE      = 16'h0039;
   localparam char_type CH_LOW_A     = 16'h0061;
   localparam char_type CH_LOW_F     = 16'h0066;
   localparam char_type CH_UP_A      = 16'h0041;
   localparam char_type CH_UP_F      = 16'h0046;

   // Configuration register indexes.
   localparam logic CSR_COPY_QUERY = 1'b0;
   localparam logic CSR_SLASH_MAP  = 1'b1;

   typedef struct packed {
      char_type out_char;
      logic     has_char;
      logic     end_of_text;
   } rsp_item_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_decode(input char_type c);
      hex_type r;
      r.ok  = 1'b0;
      r.val = 4'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         r.ok  = 1'b1;
         r.val = 4'(c - CH_ZERO);
      end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
         r.ok  = 1'b1;
         r.val = 4'(c - CH_LOW_A + char_type'(10));
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         r.ok  = 1'b1;
         r.val = 4'(c - CH_UP_A + char_type'(10));
      end
      return r;
   endfunction

endpackage

[hdl/upd_req_if.sv]
// Input channel of the URL percent decoder: one code unit per transaction.
// Depends on upd_pkg for the code unit width.
interface upd_req_if;
   logic              valid;
   logic              ready;
   upd_pkg::char_type code_unit;
   logic              is_last;

   modport source (output valid, code_unit, is_last, input ready);
   modport sink   (input valid, code_unit, is_last, output ready);
endinterface

[hdl/upd_rsp_if.sv]
// Result channel of the URL percent decoder: one decoded code unit or empty end marker per transaction.
// Depends on upd_pkg for the code unit width.
interface upd_rsp_if;
   logic              valid;
   logic              ready;
   upd_pkg::char_type out_char;
   logic              has_char;
   logic              end_of_text;

   modport source (output valid, out_char, has_char, end_of_text, input ready);
   modport sink   (input valid, out_char, has_char, end_of_text, output ready);
endinterface

[hdl/url_percent_decoder_core.sv]
// URL percent decoder: escape state, result generation and output queue.
// Depends on upd_pkg, upd_req_if and upd_rsp_if.
//
// Usage:
//   req_chan carries one URL code unit per transaction; is_last closes the URL.
//   rsp_chan carries decoded code units; end_of_text flags the last one of a
//   URL, and a result with has_char low is an empty end marker.
//   csr_we/csr_index/csr_wdata write copy_query (index 0) and
//   query_slash_to_backslash (index 1); write only while the block is idle.
// Timing:
//   An accepted code unit is decoded in the accept cycle and its results
//   (zero to three) land in a four-entry registered output queue. The queue
//   drains one result per cycle while rsp_chan is ready. req_chan.ready is
//   high while the queue holds at most one result, so one code unit per
//   cycle is taken while each yields at most one result; a failed escape
//   yields up to three and throttles input until they drain.
// Reset:
//   Clears the queue and escape state, sets both registers to 1.
//   A stalled rsp_chan holds the head result; input stops once the queue
//   holds two or more results.
module url_percent_decoder_core #(
   parameter int CHAR_WIDTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   upd_req_if.sink         req_chan,
   upd_rsp_if.source       rsp_chan,
   input  logic            csr_we,
   input  logic            csr_index,
   input  logic            csr_wdata
);

   localparam int KeepW = (CHAR_WIDTH < upd_pkg::UNIT_W) ? CHAR_WIDTH : upd_pkg::UNIT_W;
   localparam upd_pkg::char_type UnitMask = upd_pkg::char_type'((64'd1 << KeepW) - 64'd1);

   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_PCT   = 2'd1;
   localparam logic [1:0] PEND_DIGIT = 2'd2;

   localparam int QDepth = 4;

   logic                  copy_query_ff, copy_query_in;
   logic                  slash_map_ff, slash_map_in;
   logic [1:0]            pend_ff, pend_in;
   logic [6:0]            digit_ff, digit_in;
   logic                  query_ff, query_in;
   logic                  stopped_ff, stopped_in;
   upd_pkg::rsp_item_type queue_ff [QDepth];
   upd_pkg::rsp_item_type queue_in [QDepth];
   logic [2:0]            qcnt_ff, qcnt_in;

   upd_pkg::rsp_item_type cand [3];
   logic [1:0]            n_res;
   logic                  run_fresh;
   upd_pkg::char_type     unit;
   upd_pkg::hex_type      hex_c, hex_hi;
   upd_pkg::char_type     decoded;
   logic                  accept, pop;
   logic [2:0]            base;

   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready       = (qcnt_ff <= 3'd1);
   assign rsp_chan.valid       = (qcnt_ff != 3'd0);
   assign rsp_chan.out_char    = queue_ff[0].out_char;
   assign rsp_chan.has_char    = queue_ff[0].has_char;
   assign rsp_chan.end_of_text = queue_ff[0].end_of_text;

   assign unit    = req_chan.code_unit & UnitMask;
   assign hex_c   = upd_pkg::hex_decode(unit);
   assign hex_hi  = upd_pkg::hex_decode(upd_pkg::char_type'(digit_ff));
   assign decoded = upd_pkg::char_type'({hex_hi.val, hex_c.val});

   // Decode one code unit into up to three results and the next escape state.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cand[k] = '0;
      end
      n_res      = 2'd0;
      run_fresh  = 1'b0;
      pend_in    = pend_ff;
      digit_in   = digit_ff;
      query_in   = query_ff;
      stopped_in = stopped_ff;

      if (!stopped_ff) begin
         unique case (pend_ff)
            PEND_PCT: begin
               if (hex_c.ok && !req_chan.is_last) begin
                  digit_in = unit[6:0];
                  pend_in  = PEND_DIGIT;
               end else begin
                  pend_in                = PEND_NONE;
                  cand[n_res].out_char   = upd_pkg::CH_PERCENT;
                  cand[n_res].has_char   = 1'b1;
                  n_res                  = n_res + 2'd1;
                  run_fresh              = 1'b1;
               end
            end
            PEND_DIGIT: begin
               pend_in  = PEND_NONE;
               digit_in = '0;
               if (hex_c.ok) begin
                  cand[n_res].out_char = decoded;
                  cand[n_res].has_char = 1'b1;
                  n_res                = n_res + 2'd1;
                  if (decoded == upd_pkg::CH_QUESTION) begin
                     query_in = 1'b1;
                  end
               end else begin
                  cand[n_res].out_char = upd_pkg::CH_PERCENT;
                  cand[n_res].has_char = 1'b1;
                  n_res                = n_res + 2'd1;
                  cand[n_res].out_char = upd_pkg::char_type'(digit_ff);
                  cand[n_res].has_char = 1'b1;
                  n_res                = n_res + 2'd1;
                  run_fresh            = 1'b1;
               end
            end
            default: begin
               pend_in   = PEND_NONE;
               run_fresh = 1'b1;
            end
         endcase
      end

      // Fresh handling of the current code unit with no escape pending.
      if (run_fresh) begin
         if (unit == upd_pkg::CH_PERCENT) begin
            if (req_chan.is_last) begin
               cand[n_res].out_char = upd_pkg::CH_PERCENT;
               cand[n_res].has_char = 1'b1;
               n_res                = n_res + 2'd1;
            end else begin
               pend_in = PEND_PCT;
            end
         end else if (unit == upd_pkg::CH_QUESTION && !copy_query_ff) begin
            stopped_in = 1'b1;
         end else if (unit == upd_pkg::CH_SLASH && query_ff && slash_map_ff) begin
            cand[n_res].out_char = upd_pkg::CH_BACKSLASH;
            cand[n_res].has_char = 1'b1;
            n_res                = n_res + 2'd1;
         end else begin
            cand[n_res].out_char = unit;
            cand[n_res].has_char = 1'b1;
            n_res                = n_res + 2'd1;
         end
      end

      // Close the URL: mark the final result, emit an empty marker if none.
      if (req_chan.is_last) begin
         if (n_res == 2'd0) begin
            cand[0] = '0;
            n_res   = 2'd1;
         end
         cand[n_res - 2'd1].end_of_text = 1'b1;
         pend_in    = PEND_NONE;
         digit_in   = '0;
         query_in   = 1'b0;
         stopped_in = 1'b0;
      end
   end

   // Output queue: shift on pop, append new results behind the survivors.
   always_comb begin
      for (int i = 0; i < QDepth; i++) begin
         if (pop && i < QDepth - 1) begin
            queue_in[i] = queue_ff[i + 1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
      end
      base = qcnt_ff - {2'b00, pop};
      if (accept) begin
         for (int k = 0; k < 3; k++) begin
            if (k < int'(n_res)) begin
               queue_in[2'(base + 3'(k))] = cand[k];
            end
         end
      end
      qcnt_in = base + (accept ? {1'b0, n_res} : 3'd0);
   end

   always_comb begin
      copy_query_in = copy_query_ff;
      slash_map_in  = slash_map_ff;
      if (csr_we) begin
         unique case (csr_index)
            upd_pkg::CSR_COPY_QUERY: copy_query_in = csr_wdata;
            upd_pkg::CSR_SLASH_MAP:  slash_map_in  = csr_wdata;
            default:                 copy_query_in = copy_query_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         copy_query_ff <= 1'b1;
         slash_map_ff  <= 1'b1;
         pend_ff       <= PEND_NONE;
         digit_ff      <= '0;
         query_ff      <= 1'b0;
         stopped_ff    <= 1'b0;
         qcnt_ff       <= 3'd0;
      end else begin
         copy_query_ff <= copy_query_in;
         slash_map_ff  <= slash_map_in;
         qcnt_ff       <= qcnt_in;
         if (accept) begin
            pend_ff    <= pend_in;
            digit_ff   <= digit_in;
            query_ff   <= query_in;
            stopped_ff <= stopped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDepth; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

`ifndef SYNTHESIS
   a_qcnt_bound: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= 3'(QDepth))
      else $error("output queue count out of range");

   a_pend_code: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("unused escape state reached");

   a_stop_no_pend: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> (pend_ff == PEND_NONE))
      else $error("escape pending while output stopped");

   a_marker_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.has_char) |->
         (rsp_chan.end_of_text && rsp_chan.out_char == '0))
      else $error("empty marker without end flag or with data");

   a_url_close: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.is_last) |=>
         (pend_ff == PEND_NONE && !query_ff && !stopped_ff))
      else $error("state not cleared after last code unit");
`endif

endmodule
